@@ hdl/impq_pkg.sv @@
// shared types and codes for the indexed min-heap priority queue
package impq_pkg;

  // operation codes
  localparam logic [1:0] OP_INIT     = 2'd0;
  localparam logic [1:0] OP_DECREASE = 2'd1;
  localparam logic [1:0] OP_EXTRACT  = 2'd2;
  localparam logic [1:0] OP_QUERY    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // register index of vertex_count (address bit 2)
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_DK_CHK,
    S_UP_RD,
    S_UP_CMP,
    S_X_LD,
    S_DN_RD,
    S_DN_CMP,
    S_Q_RD,
    S_Q_CHK
  } impq_state_t;

endpackage

@@ hdl/indexed_min_heap_priority_queue.sv @@
// indexed binary min-heap with position map, held in on-chip memories
//
// Usage: raise start with in_op and its operands while busy is low; the item
// is taken at that edge and busy, where it rises, stays high until the result is shown. Each
// item gives one result on out_* for one cycle, marked by out_valid; the
// receiver cannot stall it, so it must take it in that cycle.
// Operations: init fills all MAX_VERTICES slots with infinite key and payload
// and identity positions, then sets the heap size to vertex_count (saturated).
// Decrease-key sifts up, extract-min moves the last entry to the root and
// sifts down, query reports membership.
// Init writes one slot per cycle. Each level of a sift-up or sift-down needs
// one registered read of the slot memory and a compare before the hole
// moves. One item at a time.
// Reset clears the sequencer and the heap size (empty heap) and sets
// vertex_count to MAX_VERTICES; memory contents are left as they are, and no
// empty-heap result depends on them. vertex_count sits at APB byte address 0;
// users must write it only while busy is low; the block does not enforce it.
module indexed_min_heap_priority_queue #(
  parameter int MAX_VERTICES = 1024,
  parameter int KEY_BITS     = 32,
  localparam int VTX_W       = $clog2(MAX_VERTICES),
  localparam int CNT_W       = VTX_W + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_op,
  input  logic [VTX_W-1:0]    in_vertex,
  input  logic [KEY_BITS-1:0] in_new_key,
  input  logic [KEY_BITS-1:0] in_new_payload,
  // result channel
  output logic                out_valid,
  output logic [VTX_W-1:0]    out_vertex,
  output logic [KEY_BITS-1:0] out_key,
  output logic [KEY_BITS-1:0] out_payload,
  output logic [1:0]          out_status,
  output logic                out_is_member,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_VERTICES);
  localparam logic [VTX_W-1:0] LAST_IDX = VTX_W'(MAX_VERTICES - 1);

  // memories
  logic [VTX_W-1:0]    slot_vtx_mem [MAX_VERTICES];
  logic [KEY_BITS-1:0] slot_key_mem [MAX_VERTICES];
  logic [KEY_BITS-1:0] slot_pay_mem [MAX_VERTICES];
  logic [VTX_W-1:0]    pos_mem      [MAX_VERTICES];

  // memory ports
  logic                slot_we;
  logic [VTX_W-1:0]    slot_waddr;
  logic [VTX_W-1:0]    slot_wvtx;
  logic [KEY_BITS-1:0] slot_wkey;
  logic [KEY_BITS-1:0] slot_wpay;
  logic                pos_we;
  logic [VTX_W-1:0]    pos_waddr;
  logic [VTX_W-1:0]    pos_wdata;
  logic [VTX_W-1:0]    rd_a_addr;
  logic [VTX_W-1:0]    rd_b_addr;
  logic [VTX_W-1:0]    pos_raddr;
  logic [VTX_W-1:0]    slot_a_vtx_r;
  logic [KEY_BITS-1:0] slot_a_key_r;
  logic [KEY_BITS-1:0] slot_a_pay_r;
  logic [VTX_W-1:0]    slot_b_vtx_r;
  logic [KEY_BITS-1:0] slot_b_key_r;
  logic [KEY_BITS-1:0] slot_b_pay_r;
  logic [VTX_W-1:0]    pos_rd_r;

  // control and working registers
  impq_pkg::impq_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    size_r, size_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [VTX_W-1:0]    sweep_r, sweep_nxt;
  logic [VTX_W-1:0]    hole_r, hole_nxt;
  logic [VTX_W-1:0]    vtx_r, vtx_nxt;
  logic [VTX_W-1:0]    mv_vtx_r, mv_vtx_nxt;
  logic [KEY_BITS-1:0] mv_key_r, mv_key_nxt;
  logic [KEY_BITS-1:0] mv_pay_r, mv_pay_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VTX_W-1:0]    out_vertex_r, out_vertex_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic [KEY_BITS-1:0] out_payload_r, out_payload_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic                out_is_member_r, out_is_member_nxt;

  // index arithmetic
  logic [VTX_W-1:0] parent_idx;
  logic [CNT_W-1:0] left_idx;
  logic [CNT_W:0]   right_idx;
  logic [CNT_W-1:0] size_m1;
  logic [CNT_W-1:0] init_size;
  logic             in_vtx_ok;
  logic             vtx_ok;
  logic             sel_l;
  logic             sel_r;
  logic [KEY_BITS-1:0] best_key;
  logic             cfg_wr;

  assign parent_idx = VTX_W'((hole_r - 1'b1) >> 1);
  assign left_idx   = {hole_r, 1'b1};
  assign right_idx  = {1'b0, left_idx} + 1'b1;
  assign size_m1    = size_r - 1'b1;
  assign init_size  = (count_r > MAX_CNT) ? MAX_CNT : count_r;
  assign in_vtx_ok  = {1'b0, in_vertex} < MAX_CNT;
  assign vtx_ok     = {1'b0, vtx_r} < MAX_CNT;

  // child selection, ties kept at the parent and the left child
  assign sel_l    = slot_a_key_r < mv_key_r;
  assign best_key = sel_l ? slot_a_key_r : mv_key_r;
  assign sel_r    = (right_idx < {1'b0, size_r}) && (slot_b_key_r < best_key);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == impq_pkg::REG_VERTEX_COUNT);
  assign prdata = (psel && paddr[2] == impq_pkg::REG_VERTEX_COUNT) ? 32'(count_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= MAX_CNT;
    end else if (cfg_wr) begin
      count_r <= pwdata[CNT_W-1:0];
    end
  end

  // slot memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_vtx_mem[slot_waddr] <= slot_wvtx;
      slot_key_mem[slot_waddr] <= slot_wkey;
      slot_pay_mem[slot_waddr] <= slot_wpay;
    end
    slot_a_vtx_r <= slot_vtx_mem[rd_a_addr];
    slot_a_key_r <= slot_key_mem[rd_a_addr];
    slot_a_pay_r <= slot_pay_mem[rd_a_addr];
    slot_b_vtx_r <= slot_vtx_mem[rd_b_addr];
    slot_b_key_r <= slot_key_mem[rd_b_addr];
    slot_b_pay_r <= slot_pay_mem[rd_b_addr];
  end

  // position memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rd_r <= pos_mem[pos_raddr];
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= impq_pkg::S_IDLE;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    sweep_r         <= sweep_nxt;
    hole_r          <= hole_nxt;
    vtx_r           <= vtx_nxt;
    mv_vtx_r        <= mv_vtx_nxt;
    mv_key_r        <= mv_key_nxt;
    mv_pay_r        <= mv_pay_nxt;
    out_vertex_r    <= out_vertex_nxt;
    out_key_r       <= out_key_nxt;
    out_payload_r   <= out_payload_nxt;
    out_status_r    <= out_status_nxt;
    out_is_member_r <= out_is_member_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    size_nxt          = size_r;
    sweep_nxt         = sweep_r;
    hole_nxt          = hole_r;
    vtx_nxt           = vtx_r;
    mv_vtx_nxt        = mv_vtx_r;
    mv_key_nxt        = mv_key_r;
    mv_pay_nxt        = mv_pay_r;
    out_valid_nxt     = 1'b0;
    out_vertex_nxt    = out_vertex_r;
    out_key_nxt       = out_key_r;
    out_payload_nxt   = out_payload_r;
    out_status_nxt    = out_status_r;
    out_is_member_nxt = out_is_member_r;
    slot_we    = 1'b0;
    slot_waddr = hole_r;
    slot_wvtx  = mv_vtx_r;
    slot_wkey  = mv_key_r;
    slot_wpay  = mv_pay_r;
    pos_we     = 1'b0;
    pos_waddr  = mv_vtx_r;
    pos_wdata  = hole_r;
    rd_a_addr  = parent_idx;
    rd_b_addr  = right_idx[VTX_W-1:0];
    pos_raddr  = vtx_r;

    unique case (state_r)
      impq_pkg::S_IDLE: begin
        pos_raddr = in_vertex;
        rd_a_addr = '0;
        rd_b_addr = size_m1[VTX_W-1:0];
        if (start) begin
          vtx_nxt           = in_vertex;
          mv_vtx_nxt        = in_vertex;
          mv_key_nxt        = in_new_key;
          mv_pay_nxt        = in_new_payload;
          out_vertex_nxt    = in_vertex;
          out_key_nxt       = '0;
          out_payload_nxt   = '0;
          out_status_nxt    = impq_pkg::ST_OK;
          out_is_member_nxt = 1'b0;
          unique case (in_op)
            impq_pkg::OP_INIT: begin
              sweep_nxt = '0;
              state_nxt = impq_pkg::S_INIT;
            end
            impq_pkg::OP_DECREASE: begin
              if (in_vtx_ok) begin
                state_nxt = impq_pkg::S_DK_CHK;
              end else begin
                out_status_nxt = impq_pkg::ST_ABSENT;
                out_valid_nxt  = 1'b1;
              end
            end
            impq_pkg::OP_EXTRACT: begin
              if (size_r == '0) begin
                out_status_nxt  = impq_pkg::ST_EMPTY;
                out_key_nxt     = '1;
                out_payload_nxt = '1;
                out_valid_nxt   = 1'b1;
              end else begin
                state_nxt = impq_pkg::S_X_LD;
              end
            end
            impq_pkg::OP_QUERY: begin
              if (in_vtx_ok) begin
                state_nxt = impq_pkg::S_Q_CHK;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      // one slot and one position per cycle
      impq_pkg::S_INIT: begin
        slot_we    = 1'b1;
        slot_waddr = sweep_r;
        slot_wvtx  = sweep_r;
        slot_wkey  = '1;
        slot_wpay  = '1;
        pos_we     = 1'b1;
        pos_waddr  = sweep_r;
        pos_wdata  = sweep_r;
        sweep_nxt  = sweep_r + 1'b1;
        if (sweep_r == LAST_IDX) begin
          size_nxt          = init_size;
          out_is_member_nxt = vtx_ok && ({1'b0, vtx_r} < init_size);
          out_valid_nxt     = 1'b1;
          state_nxt         = impq_pkg::S_IDLE;
        end
      end

      // decrease-key: check membership, open the hole
      impq_pkg::S_DK_CHK: begin
        if ({1'b0, pos_rd_r} < size_r) begin
          hole_nxt  = pos_rd_r;
          state_nxt = impq_pkg::S_UP_RD;
        end else begin
          out_status_nxt = impq_pkg::ST_ABSENT;
          out_valid_nxt  = 1'b1;
          state_nxt      = impq_pkg::S_IDLE;
        end
      end

      // sift up: fetch parent or settle at the root
      impq_pkg::S_UP_RD: begin
        if (hole_r == '0) begin
          slot_we   = 1'b1;
          pos_we    = 1'b1;
          state_nxt = impq_pkg::S_Q_RD;
        end else begin
          state_nxt = impq_pkg::S_UP_CMP;
        end
      end

      // sift up: pull parent down on a strict less-than
      impq_pkg::S_UP_CMP: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
        if (mv_key_r < slot_a_key_r) begin
          slot_wvtx = slot_a_vtx_r;
          slot_wkey = slot_a_key_r;
          slot_wpay = slot_a_pay_r;
          pos_waddr = slot_a_vtx_r;
          hole_nxt  = parent_idx;
          state_nxt = impq_pkg::S_UP_RD;
        end else begin
          state_nxt = impq_pkg::S_Q_RD;
        end
      end

      // extract: take the root, carry the last entry down from the root
      impq_pkg::S_X_LD: begin
        out_vertex_nxt  = slot_a_vtx_r;
        out_key_nxt     = slot_a_key_r;
        out_payload_nxt = slot_a_pay_r;
        mv_vtx_nxt      = slot_b_vtx_r;
        mv_key_nxt      = slot_b_key_r;
        mv_pay_nxt      = slot_b_pay_r;
        pos_we          = 1'b1;
        pos_waddr       = slot_a_vtx_r;
        pos_wdata       = size_m1[VTX_W-1:0];
        size_nxt        = size_m1;
        hole_nxt        = '0;
        state_nxt       = impq_pkg::S_DN_RD;
      end

      // sift down: fetch both children or settle at a leaf
      impq_pkg::S_DN_RD: begin
        rd_a_addr = left_idx[VTX_W-1:0];
        if (left_idx < size_r) begin
          state_nxt = impq_pkg::S_DN_CMP;
        end else begin
          slot_we   = 1'b1;
          pos_we    = 1'b1;
          state_nxt = impq_pkg::S_Q_RD;
        end
      end

      // sift down: lift the smaller child into the hole, or settle if neither is smaller
      impq_pkg::S_DN_CMP: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
        if (sel_r) begin
          slot_wvtx = slot_b_vtx_r;
          slot_wkey = slot_b_key_r;
          slot_wpay = slot_b_pay_r;
          pos_waddr = slot_b_vtx_r;
          hole_nxt  = right_idx[VTX_W-1:0];
          state_nxt = impq_pkg::S_DN_RD;
        end else if (sel_l) begin
          slot_wvtx = slot_a_vtx_r;
          slot_wkey = slot_a_key_r;
          slot_wpay = slot_a_pay_r;
          pos_waddr = slot_a_vtx_r;
          hole_nxt  = left_idx[VTX_W-1:0];
          state_nxt = impq_pkg::S_DN_RD;
        end else begin
          state_nxt = impq_pkg::S_Q_RD;
        end
      end

      // membership of the item's vertex after the update
      impq_pkg::S_Q_RD: begin
        state_nxt = impq_pkg::S_Q_CHK;
      end

      impq_pkg::S_Q_CHK: begin
        out_is_member_nxt = vtx_ok && ({1'b0, pos_rd_r} < size_r);
        out_valid_nxt     = 1'b1;
        state_nxt         = impq_pkg::S_IDLE;
      end

      default: begin
        state_nxt = impq_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  assign busy          = (state_r != impq_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_vertex    = out_vertex_r;
  assign out_key       = out_key_r;
  assign out_payload   = out_payload_r;
  assign out_status    = out_status_r;
  assign out_is_member = out_is_member_r;

endmodule

@@ tb/sv/indexed_min_heap_priority_queue_tb.sv @@
// testbench for the indexed min-heap priority queue, checked against a local heap model
`timescale 1ns / 100ps

module indexed_min_heap_priority_queue_tb;

  localparam int NV = 1024;
  localparam int KW = 32;
  localparam logic [KW-1:0] INF = '1;

  typedef struct packed {
    logic [9:0]    vertex;
    logic [KW-1:0] key;
    logic [KW-1:0] payload;
    logic [1:0]    status;
    logic          is_member;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = impq_pkg::OP_QUERY;
  logic [9:0] in_vertex = '0;
  logic [KW-1:0] in_new_key = '0;
  logic [KW-1:0] in_new_payload = '0;
  logic out_valid;
  logic [9:0] out_vertex;
  logic [KW-1:0] out_key;
  logic [KW-1:0] out_payload;
  logic [1:0] out_status;
  logic out_is_member;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  indexed_min_heap_priority_queue dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_vertex(in_vertex), .in_new_key(in_new_key),
    .in_new_payload(in_new_payload), .out_valid(out_valid), .out_vertex(out_vertex),
    .out_key(out_key), .out_payload(out_payload), .out_status(out_status),
    .out_is_member(out_is_member), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state
  logic [9:0]    m_slot_vtx [NV];
  logic [KW-1:0] m_slot_key [NV];
  logic [KW-1:0] m_slot_pay [NV];
  logic [10:0]   m_pos [NV];
  int            m_size;
  logic [10:0]   m_count;
  bit            m_loaded;

  heap_result_t expected_results[$];
  int errors = 0;
  int idle_pct = 0;
  longint cycles = 0;

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic bit model_member(logic [9:0] v);
    return m_loaded && (m_pos[v] < m_size);
  endfunction

  function automatic void model_swap(int a, int b);
    logic [9:0] va;
    logic [9:0] vb;
    logic [KW-1:0] t;
    va = m_slot_vtx[a];
    vb = m_slot_vtx[b];
    m_slot_vtx[a] = vb;
    m_slot_vtx[b] = va;
    t = m_slot_key[a]; m_slot_key[a] = m_slot_key[b]; m_slot_key[b] = t;
    t = m_slot_pay[a]; m_slot_pay[a] = m_slot_pay[b]; m_slot_pay[b] = t;
    m_pos[va] = 11'(b);
    m_pos[vb] = 11'(a);
  endfunction

  // predicted outcome of one command, updating the model heap
  function automatic heap_result_t predict_heap(logic [1:0] op, logic [9:0] v,
                                                 logic [KW-1:0] k, logic [KW-1:0] p);
    heap_result_t r;
    int i;
    int best;
    int c;
    r = '{vertex: v, key: '0, payload: '0, status: impq_pkg::ST_OK, is_member: 1'b0};
    case (op)
      impq_pkg::OP_INIT: begin
        for (i = 0; i < NV; i++) begin
          m_slot_vtx[i] = 10'(i);
          m_slot_key[i] = INF;
          m_slot_pay[i] = INF;
          m_pos[i] = 11'(i);
        end
        m_size = (m_count > NV) ? NV : m_count;
        m_loaded = 1'b1;
      end
      impq_pkg::OP_DECREASE: begin
        if (!model_member(v)) begin
          r.status = impq_pkg::ST_ABSENT;
        end else begin
          i = m_pos[v];
          m_slot_key[i] = k;
          m_slot_pay[i] = p;
          while (i > 0 && m_slot_key[i] < m_slot_key[(i-1)/2]) begin
            model_swap(i, (i-1)/2);
            i = (i-1)/2;
          end
        end
      end
      impq_pkg::OP_EXTRACT: begin
        if (m_size == 0) begin
          r.status = impq_pkg::ST_EMPTY;
          r.key = INF;
          r.payload = INF;
        end else begin
          r.vertex = m_slot_vtx[0];
          r.key = m_slot_key[0];
          r.payload = m_slot_pay[0];
          model_swap(0, m_size - 1);
          m_size--;
          i = 0;
          forever begin
            best = i;
            c = 2*i + 1;
            if (c < m_size && m_slot_key[c] < m_slot_key[best]) best = c;
            if (c + 1 < m_size && m_slot_key[c+1] < m_slot_key[best]) best = c + 1;
            if (best == i) break;
            model_swap(i, best);
            i = best;
          end
        end
      end
      default: ;
    endcase
    r.is_member = model_member(v);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    heap_result_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result vertex %0d", out_vertex);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_vertex !== e.vertex) begin
          $error("out_vertex exp %0d got %0d", e.vertex, out_vertex); errors++;
        end
        if (out_key !== e.key) begin
          $error("out_key exp %h got %h", e.key, out_key); errors++;
        end
        if (out_payload !== e.payload) begin
          $error("out_payload exp %h got %h", e.payload, out_payload); errors++;
        end
        if (out_status !== e.status) begin
          $error("out_status exp %0d got %0d", e.status, out_status); errors++;
        end
        if (out_is_member !== e.is_member) begin
          $error("out_is_member exp %0d got %0d", e.is_member, out_is_member); errors++;
        end
      end
    end
  end

  // send one item, with random idle gap before it
  task automatic send_item(logic [1:0] op, logic [9:0] v, logic [KW-1:0] k,
                           logic [KW-1:0] p);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    in_op <= op;
    in_vertex <= v;
    in_new_key <= k;
    in_new_payload <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(predict_heap(op, v, k, p));
    start <= 1'b0;
    // wait for the item to pass through before the next one
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(logic [10:0] n);
    drain_results();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {impq_pkg::REG_VERTEX_COUNT, 2'b00}; pwdata <= 32'(n);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    m_count = n;
    @(posedge clk);
  endtask

  // directed extremes and special cases
  task automatic test_directed();
    send_item(impq_pkg::OP_EXTRACT, 10'd5, '0, '0);        // empty after reset
    send_item(impq_pkg::OP_DECREASE, 10'd0, 32'd1, 32'd1); // absent on empty
    write_count(11'd1024);
    send_item(impq_pkg::OP_INIT, '0, '0, '0);
    send_item(impq_pkg::OP_DECREASE, 10'h3ff, 32'd0, INF);
    send_item(impq_pkg::OP_DECREASE, 10'd0, INF, 32'd0);   // equal key stays
    send_item(impq_pkg::OP_DECREASE, 10'd512, 32'd7, 32'hA5A5A5A5);
    send_item(impq_pkg::OP_DECREASE, 10'd513, 32'd7, 32'h5A5A5A5A); // tie
    send_item(impq_pkg::OP_DECREASE, 10'd512, 32'd100, 32'd3); // raised key
    send_item(impq_pkg::OP_QUERY, 10'd512, '0, '0);
    repeat (4) send_item(impq_pkg::OP_EXTRACT, 10'd1, '0, '0);
    send_item(impq_pkg::OP_DECREASE, 10'h3ff, 32'd1, 32'd1); // extracted, absent
    send_item(impq_pkg::OP_QUERY, 10'h3ff, '0, '0);
    write_count(11'd0);
    send_item(impq_pkg::OP_INIT, '0, '0, '0);
    send_item(impq_pkg::OP_EXTRACT, 10'd2, '0, '0);
    write_count(11'h7ff);                         // saturates
    send_item(impq_pkg::OP_INIT, '0, '0, '0);
    send_item(impq_pkg::OP_QUERY, 10'd1023, '0, '0);
    write_count(11'd1);
    send_item(impq_pkg::OP_INIT, '0, '0, '0);
    send_item(impq_pkg::OP_QUERY, 10'd1, '0, '0);          // above count
    send_item(impq_pkg::OP_DECREASE, 10'd0, 32'd9, 32'd9);
    send_item(impq_pkg::OP_EXTRACT, 10'd0, '0, '0);
  endtask

  // random phase: mostly decreases and extracts on a small heap
  task automatic test_random(int n_items, int pct);
    int i;
    int r;
    logic [KW-1:0] k;
    idle_pct = pct;
    write_count(11'($urandom_range(2, 40)));
    send_item(impq_pkg::OP_INIT, 10'($urandom), '0, '0);
    for (i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      k = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(15));
      if ($urandom_range(9) == 0) k = ~k;
      if (r < 2)
        send_item(impq_pkg::OP_INIT, 10'($urandom), 32'($urandom), 32'($urandom));
      else if (r < 50)
        send_item(impq_pkg::OP_DECREASE, ($urandom_range(4) == 0) ? 10'($urandom) :
                  10'($urandom_range(m_count)), k, 32'($urandom));
      else if (r < 85)
        send_item(impq_pkg::OP_EXTRACT, 10'($urandom), 32'($urandom), 32'($urandom));
      else
        send_item(impq_pkg::OP_QUERY, 10'($urandom), 32'($urandom), 32'($urandom));
      if (i == n_items / 2) drain_results(); // sender holds off until all results in
    end
  endtask

  initial begin
    m_count = 11'd1024;
    m_size = 0;
    m_loaded = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(280, 11);
    test_random(280, 63);
    test_random(290, 0);
    drain_results();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
